// ===== rtl/jdcd_pkg.sv =====
// shared widths, constants and stage count for the day number to date converter
package jdcd_pkg;

  localparam int unsigned DayW   = 30;
  localparam int unsigned DomW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 22;

  localparam int unsigned NumStages = 9;

  localparam logic [DayW-1:0] DayLimit  = 30'd1000000000;
  localparam logic [DayW-1:0] GregStart = 30'd2299161;

  // cycle lengths in days
  localparam logic [31:0] Cycle400 = 32'd146097;
  localparam logic [31:0] Cycle4   = 32'd1461;

  // reciprocals for the constant divisions; the year-length ones are worked out at elaboration, the others are literals
  localparam logic [31:0] RecipCycle400 = 32'((64'd1 << 49) / 64'd146097);
  localparam logic [31:0] RecipCycle4   = 32'((64'd1 << 42) / 64'd1461);
  localparam logic [9:0]  RecipMonth    = 10'd857;  // 2^17 / 153, rounded up
  localparam logic [7:0]  RecipFive     = 8'd205;   // 2^10 / 5, rounded up

  localparam logic [23:0] YearBias = 24'd4716;

endpackage

// ===== rtl/jdcd_req_if.sv =====
// request channel: one day number per transfer
interface jdcd_req_if import jdcd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [DayW-1:0] day_number;

  modport source (output valid, output day_number, input ready);
  modport sink   (input valid, input day_number, output ready);
endinterface

// ===== rtl/jdcd_rsp_if.sv =====
// response channel: one calendar date per transfer
interface jdcd_rsp_if import jdcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DomW-1:0]   day_of_month;
  logic [MonthW-1:0] month;
  logic [YearW-1:0]  year;
  logic              before_christ;

  modport source (output valid, output day_of_month, output month, output year,
                  output before_christ, input ready);
  modport sink   (input valid, input day_of_month, input month, input year,
                  input before_christ, output ready);
endinterface

// ===== rtl/julian_day_to_calendar_date.sv =====
// a request passes through the stage registers 1 to 9 in order before its date appears on the response channel
// throughput: one request per cycle while the response is not stalled; each of the nine stages holds one request
// the slowest stages are the two 32x32 reciprocal multiplies (400-year and 4-year cycles)
// a stalled response only holds the stages behind it that are full, bubbles still close up
// reset clears the valid bits of every stage; the datapath registers are not reset
module julian_day_to_calendar_date import jdcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  jdcd_req_if.sink          req_i,
  jdcd_rsp_if.source        rsp_o
);

  // per-stage valid bits and the ready chain running back from the output
  logic [NumStages:1] v_q;
  logic [NumStages:1] adv;

  always_comb begin
    adv[NumStages] = !v_q[NumStages] || rsp_o.ready;
    for (int s = NumStages - 1; s >= 1; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end

  assign req_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) begin
        v_q[1] <= req_i.valid;
      end
      for (int s = 2; s <= NumStages; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // stage 1: clamp the day count, form 4n + 274277 for the gregorian correction
  logic [DayW-1:0] n_clamp;
  logic [31:0]     x_d;
  logic [DayW-1:0] n1_q;
  logic [31:0]     x1_q;
  logic            greg1_q;

  assign n_clamp = (req_i.day_number > DayLimit) ? DayLimit : req_i.day_number;
  assign x_d     = {n_clamp, 2'b00} + 32'd274277;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      n1_q    <= n_clamp;
      x1_q    <= x_d;
      greg1_q <= (n_clamp >= GregStart);
    end
  end

  // stage 2: reciprocal multiply, estimate of x / 146097 (low by at most one)
  logic [63:0]     prod400;
  logic [DayW-1:0] n2_q;
  logic [31:0]     x2_q;
  logic [14:0]     qest2_q;
  logic            greg2_q;

  assign prod400 = 64'(x1_q) * 64'(RecipCycle400);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      n2_q    <= n1_q;
      x2_q    <= x1_q;
      qest2_q <= prod400[63:49];
      greg2_q <= greg1_q;
    end
  end

  // stage 3: back-multiply and correct the quotient by one where needed
  logic [32:0]     rem400;
  logic [DayW-1:0] n3_q;
  logic [14:0]     q3_q;
  logic            greg3_q;

  assign rem400 = 33'(x2_q) - 33'(qest2_q) * 33'(Cycle400);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      n3_q    <= n2_q;
      q3_q    <= qest2_q + 15'((rem400 >= 33'(Cycle400)) ? 1 : 0);
      greg3_q <= greg2_q;
    end
  end

  // stage 4: shifted day count f, then e = 4f + 3
  logic [16:0] skip_days;
  logic [30:0] f_d;
  logic [31:0] e4_q;

  assign skip_days = (17'(q3_q) * 17'd3) >> 2;
  // dropped leap days of the century rule, only after the calendar switch
  assign f_d = 31'(n3_q) + 31'd1401 + (greg3_q ? (31'(skip_days) - 31'd38) : 31'd0);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      e4_q <= {f_d[29:0], 2'b11};
    end
  end

  // stage 5: reciprocal multiply, estimate of e / 1461
  logic [63:0]      prod4;
  logic [31:0]      e5_q;
  logic [YearW-1:0] qyest5_q;

  assign prod4 = 64'(e4_q) * 64'(RecipCycle4);

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      e5_q     <= e4_q;
      qyest5_q <= prod4[63:42];
    end
  end

  // stage 6: correct the 4-year quotient, day of the shifted year, h = 5g + 2
  logic [32:0] rem4_raw;
  logic        rem4_over;
  logic [11:0] rem4;
  logic [8:0]  doy;
  logic [YearW-1:0] qy6_q;
  logic [10:0] h6_q;

  assign rem4_raw  = 33'(e5_q) - 33'(qyest5_q) * 33'(Cycle4);
  assign rem4_over = (rem4_raw >= 33'(Cycle4));
  assign rem4      = rem4_raw[11:0] - (rem4_over ? 12'(Cycle4) : 12'd0);
  assign doy       = rem4[10:2];

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      qy6_q <= qyest5_q + YearW'(rem4_over ? 1 : 0);
      h6_q  <= 11'(doy) * 11'd5 + 11'd2;
    end
  end

  // stage 7: month index h / 153 by reciprocal
  logic [20:0]      prod_mon;
  logic [YearW-1:0] qy7_q;
  logic [10:0]      h7_q;
  logic [3:0]       mi7_q;

  assign prod_mon = 21'(h6_q) * 21'(RecipMonth);

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      qy7_q <= qy6_q;
      h7_q  <= h6_q;
      mi7_q <= prod_mon[20:17];
    end
  end

  // stage 8: remainder within the month, calendar month, year and era
  logic [10:0]        rmon_full;
  logic               jan_feb;
  logic signed [23:0] astro_year;
  logic               bc_d;
  logic [7:0]         r8_q;
  logic [MonthW-1:0]  mon8_q;
  logic [YearW-1:0]   yr8_q;
  logic               bc8_q;

  assign rmon_full = h7_q - 11'(mi7_q) * 11'd153;
  // march-based months: index 10 and 11 are january and february of the next year
  assign jan_feb    = (mi7_q >= 4'd10);
  assign astro_year = $signed({2'b00, qy7_q}) - $signed(YearBias)
                    + $signed(24'(jan_feb ? 1 : 0));
  assign bc_d       = (astro_year <= 24'sd0);

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      r8_q   <= rmon_full[7:0];
      mon8_q <= jan_feb ? (mi7_q - 4'd9) : (mi7_q + 4'd3);
      yr8_q  <= bc_d ? YearW'(24'sd1 - astro_year) : YearW'(astro_year);
      bc8_q  <= bc_d;
    end
  end

  // stage 9: day of month r / 5 + 1, output register
  logic [14:0]       prod_dom;
  logic [DomW-1:0]   dom9_q;
  logic [MonthW-1:0] mon9_q;
  logic [YearW-1:0]  yr9_q;
  logic              bc9_q;

  assign prod_dom = 15'(r8_q) * 15'(RecipFive);

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      dom9_q <= prod_dom[14:10] + 5'd1;
      mon9_q <= mon8_q;
      yr9_q  <= yr8_q;
      bc9_q  <= bc8_q;
    end
  end

  assign rsp_o.valid         = v_q[NumStages];
  assign rsp_o.day_of_month  = dom9_q;
  assign rsp_o.month         = mon9_q;
  assign rsp_o.year          = yr9_q;
  assign rsp_o.before_christ = bc9_q;

`ifndef SYNTHESIS
  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> v_q[1])
    else $error("accepted request did not enter the first stage");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.month >= 4'd1 && rsp_o.month <= 4'd12))
    else $error("month out of range");

  a_dom_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.day_of_month >= 5'd1))
    else $error("day of month is zero");

  a_bc_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.before_christ) |-> (rsp_o.year <= 22'd4713))
    else $error("bc year beyond the epoch");
`endif

endmodule
